// File: hw/rtl/nmlt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nmlt_pkg: shared types, constants and table functions
// Field widths, level-tracker constants, the control struct carried from the
// front part to the back part, and the quarter-wave sine/cosine generator.
// ----------------------------------------------------------------------------
package nmlt_pkg;

	localparam int OFFSET_W     = 21;
	localparam int PHASE_W      = 21;
	localparam int LEVEL_W      = 48;
	localparam int LEVEL_FRAC_W = 32;
	localparam int LEVEL_OUT_W  = 16;
	localparam int WEIGHT_W     = 16;
	localparam int COEF_W       = 16;
	localparam int COEF_FRAC_W  = 15;
	localparam int QUEUE_DEPTH  = 4;
	localparam int TAYLOR_TERMS = 8;

	localparam logic [WEIGHT_W-1:0] LEVEL_WEIGHT = 16'd42950;
	localparam logic [63:0]         TWO_PI_Q30   = 64'd6746518852;

	typedef struct packed {
		logic clear;
		logic rotate;
	} ctl_t;

	typedef enum logic [1:0] {
		QUAD_FIRST,
		QUAD_SECOND,
		QUAD_THIRD,
		QUAD_FOURTH
	} quad_t;

	// Clamp a Q30 value to [0, 1.0] and round half up to Q15, capped at 32767.
	function automatic logic [COEF_W-1:0] q30_to_q15(input longint v);
		longint t;
		t = v;
		if (t < 0) begin
			t = 0;
		end
		if (t > (longint'(1) <<< 30)) begin
			t = longint'(1) <<< 30;
		end
		t = (t + (longint'(1) <<< 14)) >>> 15;
		if (t > 32767) begin
			t = 32767;
		end
		return COEF_W'(t);
	endfunction

	// Shift-subtract unsigned quotient, floor(num / den); runs only while the
	// constant table is built.
	function automatic logic [63:0] udiv64(input logic [63:0] num,
		input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		int          i;
		quo = '0;
		rem = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// First-quadrant cosine and sine for entry k of a 2^tb table, {cos, sin}.
	function automatic logic [2*COEF_W-1:0] quarter_entry(input int unsigned k,
		input int unsigned tb);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] ts;
		logic [63:0] tc;
		longint      ss;
		longint      sc;
		int unsigned n;
		x  = (TWO_PI_Q30 * 64'(k) + (64'd1 << (tb - 1))) >> tb;
		x2 = (x * x) >> 30;
		ts = x;
		tc = 64'd1 << 30;
		ss = longint'(x);
		sc = longint'(tc);
		for (n = 1; n <= TAYLOR_TERMS; n++) begin
			ts = udiv64((ts * x2) >> 30, 64'(2 * n) * 64'(2 * n + 1));
			tc = udiv64((tc * x2) >> 30, 64'(2 * n - 1) * 64'(2 * n));
			if (n[0]) begin
				ss = ss - longint'(ts);
				sc = sc - longint'(tc);
			end else begin
				ss = ss + longint'(ts);
				sc = sc + longint'(tc);
			end
		end
		return {q30_to_q15(sc), q30_to_q15(ss)};
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/nmlt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nmlt_front: input side of the mixer
// Accepts samples, flags rotation and clear, and reduces the frequency offset
// to a forward phase step in [0, RATE) before handing items to the queue.
// ----------------------------------------------------------------------------
module nmlt_front #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int RATE         = 2048000
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [SAMPLE_WIDTH-1:0]           in_re,
	input  wire logic [SAMPLE_WIDTH-1:0]           in_im,
	input  wire logic [nmlt_pkg::OFFSET_W-1:0]     in_offset,
	input  wire logic                              in_clear,
	input  wire logic                              q_full,
	output logic                                   push,
	output logic [2*SAMPLE_WIDTH+nmlt_pkg::PHASE_W+$bits(nmlt_pkg::ctl_t)-1:0] push_data
);
	import nmlt_pkg::*;

	localparam int QW = 2 * SAMPLE_WIDTH + PHASE_W + $bits(ctl_t);
	localparam logic [63:0] OFF_M = (64'd1 << PHASE_W) / 64'(RATE);
	localparam int OFF_M_W = $clog2(OFF_M + 64'd1);
	localparam int OFF_P_W = OFFSET_W + OFF_M_W;
	localparam int QR_W    = OFF_M_W + PHASE_W;
	localparam int R_W     = PHASE_W + 1;
	localparam logic [R_W-1:0] RATE_R  = R_W'(RATE);
	localparam logic [R_W-1:0] RATE2_R = R_W'(2 * RATE);

	logic                    adv;
	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	logic [SAMPLE_WIDTH-1:0] re_s1, re_s2, re_s3, re_s4;
	logic [SAMPLE_WIDTH-1:0] im_s1, im_s2, im_s3, im_s4;
	ctl_t                    ctl_in, ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic                    neg_s1, neg_s2, neg_s3, neg_s4;
	logic [OFFSET_W-1:0]     abs_in, abs_s1, abs_s2, abs_s3;
	logic [OFF_P_W-1:0]      prod_s2;
	logic [QR_W-1:0]         qr_s3;
	logic [R_W-1:0]          rraw_s4;
	logic                    ge;
	logic [R_W-1:0]          red;
	logic [R_W-1:0]          up_mod;
	logic [PHASE_W-1:0]      step;

	// Whole front moves together; hold while the last stage cannot push.
	assign adv      = !vld_s4 || !q_full;
	assign in_ready = adv;
	assign push     = vld_s4 && adv;

	assign ctl_in.clear  = in_clear;
	assign ctl_in.rotate = |in_offset;
	assign abs_in = in_offset[OFFSET_W-1] ? OFFSET_W'(-in_offset) : in_offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			re_s1  <= in_re;
			im_s1  <= in_im;
			ctl_s1 <= ctl_in;
			neg_s1 <= in_offset[OFFSET_W-1];
			abs_s1 <= abs_in;

			// Quotient estimate by reciprocal, low by at most one.
			re_s2   <= re_s1;
			im_s2   <= im_s1;
			ctl_s2  <= ctl_s1;
			neg_s2  <= neg_s1;
			abs_s2  <= abs_s1;
			prod_s2 <= OFF_P_W'(abs_s1) * OFF_P_W'(OFF_M[OFF_M_W-1:0]);

			re_s3  <= re_s2;
			im_s3  <= im_s2;
			ctl_s3 <= ctl_s2;
			neg_s3 <= neg_s2;
			abs_s3 <= abs_s2;
			qr_s3  <= QR_W'(prod_s2[OFF_P_W-1:PHASE_W]) * QR_W'(RATE);

			re_s4   <= re_s3;
			im_s4   <= im_s3;
			ctl_s4  <= ctl_s3;
			neg_s4  <= neg_s3;
			rraw_s4 <= R_W'(QR_W'(abs_s3) - qr_s3);
		end
	end

	// Remainder is below 2*RATE: one conditional subtract finishes it. A positive
	// offset steps backward, so turn it into the forward step RATE - r.
	always_comb begin
		ge     = rraw_s4 >= RATE_R;
		red    = ge ? rraw_s4 - RATE_R : rraw_s4;
		up_mod = ge ? RATE2_R - rraw_s4 : RATE_R - rraw_s4;
		if (neg_s4) begin
			step = red[PHASE_W-1:0];
		end else if (red == '0) begin
			step = '0;
		end else begin
			step = up_mod[PHASE_W-1:0];
		end
	end

	assign push_data = QW'({ctl_s4, step, im_s4, re_s4});

endmodule
`default_nettype wire

// File: hw/rtl/nmlt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nmlt_queue: short FIFO between front and back
// Register-based queue that lets either side stall without stopping the other.
// ----------------------------------------------------------------------------
module nmlt_queue #(
	parameter int WIDTH = 56
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  full,
	output logic                  empty
);
	import nmlt_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full     = count_q == (PTR_W + 1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/nmlt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nmlt_back: phase accumulator, NCO table, rotation and level tracker
// Pipeline that advances as a whole; holds the output register.
// ----------------------------------------------------------------------------
module nmlt_back #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int RATE         = 2048000,
	parameter int TABLE_BITS   = 12
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                q_empty,
	input  wire logic [2*SAMPLE_WIDTH+nmlt_pkg::PHASE_W+$bits(nmlt_pkg::ctl_t)-1:0] q_data,
	output logic                                     pop,
	input  wire logic                                advance,
	output logic                                     out_valid,
	output logic [SAMPLE_WIDTH-1:0]                  out_re,
	output logic [SAMPLE_WIDTH-1:0]                  out_im,
	output logic [nmlt_pkg::LEVEL_OUT_W-1:0]         out_level
);
	import nmlt_pkg::*;

	localparam int SW     = SAMPLE_WIDTH;
	localparam int QW     = 2 * SW + PHASE_W + $bits(ctl_t);
	localparam int NSTAGE = 11;
	localparam int R_W    = PHASE_W + 1;
	localparam logic [R_W-1:0] RATE_R = R_W'(RATE);
	localparam logic [63:0] IDX_M = (64'd1 << (PHASE_W + TABLE_BITS)) / 64'(RATE);
	localparam int IDX_M_W = $clog2(IDX_M + 64'd1);
	localparam int PI_W    = PHASE_W + IDX_M_W;
	localparam int QPR_W   = TABLE_BITS + 1 + PHASE_W;
	localparam int QN      = 2 ** (TABLE_BITS - 2);
	localparam int PW      = SW + COEF_W;
	localparam int SUM_W   = PW + 1;
	localparam int SH_W    = SUM_W - COEF_FRAC_W;
	localparam int MAG_W   = SW + 1;
	localparam int MW_W    = MAG_W + WEIGHT_W;
	localparam int LP_W    = LEVEL_W + WEIGHT_W;
	localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (COEF_FRAC_W - 1);

	typedef logic [2*COEF_W-1:0] rom_t [QN];

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k < QN; k++) begin
			r[k] = quarter_entry(k, TABLE_BITS);
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	function automatic logic [SW-1:0] sat_sample(input logic [SH_W-1:0] v);
		logic [SW-1:0] r;
		if ((&v[SH_W-1:SW-1]) || !(|v[SH_W-1:SW-1])) begin
			r = v[SW-1:0];
		end else if (v[SH_W-1]) begin
			r = {1'b1, {(SW - 1){1'b0}}};
		end else begin
			r = {1'b0, {(SW - 1){1'b1}}};
		end
		return r;
	endfunction

	logic [NSTAGE:1]            vld_q;
	logic                       out_valid_q;
	logic [PHASE_W-1:0]         phase_q;
	logic [LEVEL_W-1:0]         level_q;

	logic signed [SW-1:0]       re_s1, re_s2, re_s3, re_s4, re_s5, re_s6, re_s7, re_s8;
	logic signed [SW-1:0]       im_s1, im_s2, im_s3, im_s4, im_s5, im_s6, im_s7, im_s8;
	ctl_t                       ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	ctl_t                       ctl_s7, ctl_s8, ctl_s9, ctl_s10, ctl_s11;
	logic [PHASE_W-1:0]         step_s1;
	logic [PHASE_W-1:0]         phase_s2, phase_s3, phase_s4;
	logic [PI_W-1:0]            prodi_s3;
	logic [TABLE_BITS-1:0]      qest_s4;
	logic [QPR_W-1:0]           qpr_s4;
	logic [TABLE_BITS-1:0]      idx_s5;
	logic [2*COEF_W-1:0]        cs_s6;
	quad_t                      quad_s6;
	logic signed [PW-1:0]       xc_s7, ys_s7, xs_s7, yc_s7;
	logic signed [SUM_W-1:0]    sr_s8, si_s8;
	logic [SW-1:0]              mre_s9, mre_s10, mre_s11;
	logic [SW-1:0]              mim_s9, mim_s10, mim_s11;
	logic [MAG_W-1:0]           mag_s10;
	logic [MW_W-1:0]            magw_s11;
	logic [SW-1:0]              out_re_q, out_im_q;
	logic [LEVEL_OUT_W-1:0]     out_level_q;

	logic [PHASE_W-1:0]         phase_base;
	logic [R_W-1:0]             phase_sum;
	logic [R_W-1:0]             phase_wrap;
	logic [PHASE_W-1:0]         phase_nx;
	logic [TABLE_BITS:0]        qp1;
	logic                       idx_hit;
	logic signed [COEF_W-1:0]   c_raw, s_raw, c_v, s_v;
	logic [SH_W-1:0]            shr, shi;
	logic [SW-1:0]              are, aim, big, lit;
	logic [LEVEL_W-1:0]         lvl_base;
	logic [LP_W-1:0]            lvl_prod;
	logic [LEVEL_W:0]           lvl_sum;
	logic [LEVEL_W-1:0]         lvl_nx;

	assign pop = advance && !q_empty;

	// Phase recurrence: clear first, then step forward and wrap once.
	always_comb begin
		phase_base = ctl_s1.clear ? '0 : phase_q;
		phase_sum  = R_W'(phase_base) + R_W'(step_s1);
		phase_wrap = (phase_sum >= RATE_R) ? phase_sum - RATE_R : phase_sum;
		phase_nx   = ctl_s1.rotate ? phase_wrap[PHASE_W-1:0] : phase_base;
	end

	// Table index: estimate is low by at most one, test the next value.
	assign qp1     = (TABLE_BITS + 1)'(prodi_s3[PI_W-1:PHASE_W]
		& {{(IDX_M_W - TABLE_BITS){1'b0}}, {TABLE_BITS{1'b1}}}) + 1'b1;
	assign idx_hit = QPR_W'({phase_s4, {TABLE_BITS{1'b0}}}) >= qpr_s4;

	// Unfold the quarter wave to the full circle.
	always_comb begin
		c_raw = cs_s6[2*COEF_W-1:COEF_W];
		s_raw = cs_s6[COEF_W-1:0];
		case (quad_s6)
			QUAD_FIRST: begin
				c_v = c_raw;
				s_v = s_raw;
			end
			QUAD_SECOND: begin
				c_v = -s_raw;
				s_v = c_raw;
			end
			QUAD_THIRD: begin
				c_v = -c_raw;
				s_v = -s_raw;
			end
			QUAD_FOURTH: begin
				c_v = s_raw;
				s_v = -c_raw;
			end
			default: begin
				c_v = c_raw;
				s_v = s_raw;
			end
		endcase
	end

	assign shr = SH_W'(sr_s8 >>> COEF_FRAC_W);
	assign shi = SH_W'(si_s8 >>> COEF_FRAC_W);

	always_comb begin
		are = mre_s9[SW-1] ? SW'(-mre_s9) : mre_s9;
		aim = mim_s9[SW-1] ? SW'(-mim_s9) : mim_s9;
		big = (are > aim) ? are : aim;
		lit = (are > aim) ? aim : are;
	end

	// Leaky average: level - level*w/2^32 + mag*w, saturated.
	always_comb begin
		lvl_base = ctl_s11.clear ? '0 : level_q;
		lvl_prod = LP_W'(lvl_base) * LP_W'(LEVEL_WEIGHT);
		lvl_sum  = (LEVEL_W + 1)'(lvl_base)
			- (LEVEL_W + 1)'(lvl_prod[LP_W-1:LEVEL_FRAC_W])
			+ (LEVEL_W + 1)'(magw_s11);
		lvl_nx   = lvl_sum[LEVEL_W] ? {LEVEL_W{1'b1}} : lvl_sum[LEVEL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
			phase_q     <= '0;
			level_q     <= '0;
		end else if (advance) begin
			vld_q       <= {vld_q[NSTAGE-1:1], pop};
			out_valid_q <= vld_q[NSTAGE];
			if (vld_q[1]) begin
				phase_q <= phase_nx;
			end
			if (vld_q[NSTAGE]) begin
				level_q <= lvl_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			re_s1   <= q_data[SW-1:0];
			im_s1   <= q_data[2*SW-1:SW];
			step_s1 <= q_data[2*SW+PHASE_W-1:2*SW];
			ctl_s1  <= ctl_t'(q_data[QW-1:2*SW+PHASE_W]);

			re_s2    <= re_s1;
			im_s2    <= im_s1;
			ctl_s2   <= ctl_s1;
			phase_s2 <= phase_nx;

			re_s3    <= re_s2;
			im_s3    <= im_s2;
			ctl_s3   <= ctl_s2;
			phase_s3 <= phase_s2;
			prodi_s3 <= PI_W'(phase_s2) * PI_W'(IDX_M[IDX_M_W-1:0]);

			re_s4    <= re_s3;
			im_s4    <= im_s3;
			ctl_s4   <= ctl_s3;
			phase_s4 <= phase_s3;
			qest_s4  <= qp1[TABLE_BITS-1:0] - 1'b1;
			qpr_s4   <= QPR_W'(qp1) * QPR_W'(RATE);

			re_s5  <= re_s4;
			im_s5  <= im_s4;
			ctl_s5 <= ctl_s4;
			idx_s5 <= idx_hit ? qest_s4 + 1'b1 : qest_s4;

			re_s6   <= re_s5;
			im_s6   <= im_s5;
			ctl_s6  <= ctl_s5;
			cs_s6   <= ROM[idx_s5[TABLE_BITS-3:0]];
			quad_s6 <= quad_t'(idx_s5[TABLE_BITS-1:TABLE_BITS-2]);

			re_s7  <= re_s6;
			im_s7  <= im_s6;
			ctl_s7 <= ctl_s6;
			xc_s7  <= PW'(re_s6) * PW'(c_v);
			ys_s7  <= PW'(im_s6) * PW'(s_v);
			xs_s7  <= PW'(re_s6) * PW'(s_v);
			yc_s7  <= PW'(im_s6) * PW'(c_v);

			re_s8  <= re_s7;
			im_s8  <= im_s7;
			ctl_s8 <= ctl_s7;
			sr_s8  <= SUM_W'(xc_s7) - SUM_W'(ys_s7) + RND;
			si_s8  <= SUM_W'(xs_s7) + SUM_W'(yc_s7) + RND;

			// Zero offset passes the sample through untouched.
			ctl_s9 <= ctl_s8;
			mre_s9 <= ctl_s8.rotate ? sat_sample(shr) : re_s8;
			mim_s9 <= ctl_s8.rotate ? sat_sample(shi) : im_s8;

			ctl_s10 <= ctl_s9;
			mre_s10 <= mre_s9;
			mim_s10 <= mim_s9;
			mag_s10 <= MAG_W'(big) + MAG_W'(lit >> 1);

			ctl_s11  <= ctl_s10;
			mre_s11  <= mre_s10;
			mim_s11  <= mim_s10;
			magw_s11 <= MW_W'(mag_s10) * MW_W'(LEVEL_WEIGHT);

			out_re_q    <= mre_s11;
			out_im_q    <= mim_s11;
			out_level_q <= lvl_nx[LEVEL_W-1:LEVEL_FRAC_W];
		end
	end

	assign out_valid = out_valid_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;
	assign out_level = out_level_q;

endmodule
`default_nettype wire

// File: hw/rtl/nco_mixer_level_tracker_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nco_mixer_level_tracker_unit: NCO frequency-correction mixer with level
// tracker
// Rotates each complex sample by the accumulated phase of its frequency
// offset and tracks a leaky average of the output magnitude.
// ----------------------------------------------------------------------------
// Path: a sample accepted on s_axis passes 4 front stages, the queue, 11 back
// stages and the output register before it shows up on m_axis.
// Throughput: one sample per cycle while m_axis does not stall; the phase and
// level recurrences each close through a single register, and the NCO table is
// a constant ROM read once. Reset: phase and level return to zero, the queue
// and all stages empty; samples are taken as soon as reset releases.
// ----------------------------------------------------------------------------
module nco_mixer_level_tracker_unit #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int RATE         = 2048000,
	parameter int TABLE_BITS   = 12,
	localparam int IN_BITS     = 2 * SAMPLE_WIDTH + nmlt_pkg::OFFSET_W,
	localparam int IN_W        = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS    = 2 * SAMPLE_WIDTH + nmlt_pkg::LEVEL_OUT_W,
	localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// slave side: one transfer per sample
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata, low bit up: sample_re, sample_im, freq_offset, zero pad
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	// tuser: clear
	input  wire logic             s_axis_tuser,
	// master side: one transfer per result
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// tdata, low bit up: mixed_re, mixed_im, signal_level, zero pad
	output logic [OUT_W-1:0]      m_axis_tdata
);
	import nmlt_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int QW = 2 * SW + PHASE_W + $bits(ctl_t);

	logic [SW-1:0]          in_re;
	logic [SW-1:0]          in_im;
	logic [OFFSET_W-1:0]    in_offset;
	logic                   q_push;
	logic [QW-1:0]          q_push_data;
	logic                   q_pop;
	logic [QW-1:0]          q_pop_data;
	logic                   q_full;
	logic                   q_empty;
	logic                   back_adv;
	logic [SW-1:0]          mixed_re;
	logic [SW-1:0]          mixed_im;
	logic [LEVEL_OUT_W-1:0] signal_level;

	// Unpack the slave-side transfer; pad bits are ignored.
	assign in_re     = s_axis_tdata[SW-1:0];
	assign in_im     = s_axis_tdata[2*SW-1:SW];
	assign in_offset = s_axis_tdata[IN_BITS-1:2*SW];

	// Front: classify the sample and reduce its offset to a phase step.
	nmlt_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.RATE         (RATE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_re     (in_re),
		.in_im     (in_im),
		.in_offset (in_offset),
		.in_clear  (s_axis_tuser),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_push_data)
	);

	// Queue: absorbs a back-side stall so the front keeps filling.
	nmlt_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Advance the back pipeline whenever the output register is free or
	// its result is taken in this cycle; otherwise hold every stage.
	assign back_adv = !m_axis_tvalid || m_axis_tready;

	// Back: phase accumulator, NCO lookup, rotation, level tracker.
	nmlt_back #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.RATE         (RATE),
		.TABLE_BITS   (TABLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_pop_data),
		.pop       (q_pop),
		.advance   (back_adv),
		.out_valid (m_axis_tvalid),
		.out_re    (mixed_re),
		.out_im    (mixed_im),
		.out_level (signal_level)
	);

	// Pack the result, zero pad on top.
	assign m_axis_tdata = OUT_W'({signal_level, mixed_im, mixed_re});

endmodule
`default_nettype wire
